>>> rtl/ggcs_pkg.sv
// shared widths, constants and types of the geo grid cell store
package ggcs_pkg;

  localparam int unsigned CoordW    = 21;
  localparam int unsigned SpacingW  = 16;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned CmdW      = 2;
  localparam int unsigned IndexW    = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;

  localparam int unsigned GridCells = 65536;
  localparam int unsigned GridAw    = $clog2(GridCells);

  localparam int unsigned LonW      = CoordW + 1;
  localparam int unsigned QuoW      = CoordW + 1;
  localparam int unsigned ProdW     = 2 * QuoW;

  localparam int unsigned DivNW     = CoordW + 2;
  localparam int unsigned DivDW     = SpacingW + 1;
  localparam int unsigned DivCntW   = $clog2(DivNW);

  localparam logic signed [LonW-1:0] WrapHalf = LonW'(180000);
  localparam logic signed [LonW-1:0] WrapFull = LonW'(360000);

  localparam logic [ValueW-1:0] EmptyReset = 32'h8000_0000;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

>>> rtl/ggcs_ram.sv
// generic single-port ram with registered read
module ggcs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/ggcs_div.sv
// iterative restoring divider, one quotient bit per cycle
module ggcs_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ggcs_pkg::DivNW-1:0]    dividend_i,
  input  logic [ggcs_pkg::DivDW-1:0]    divisor_i,
  output ggcs_pkg::div_status_t         status_o,
  output logic [ggcs_pkg::DivNW-1:0]    quotient_o
);

  logic [ggcs_pkg::DivDW-1:0]   rem_q;
  logic [ggcs_pkg::DivDW-1:0]   divisor_q;
  logic [ggcs_pkg::DivNW-1:0]   quo_q;
  logic [ggcs_pkg::DivCntW-1:0] cnt_q;
  logic                         busy_q;
  logic                         done_q;

  logic [ggcs_pkg::DivDW:0]     trial;
  logic [ggcs_pkg::DivDW:0]     diff;
  logic                         fits;

  assign trial = {rem_q, quo_q[ggcs_pkg::DivNW-1]};
  assign diff  = trial - {1'b0, divisor_q};
  assign fits  = trial >= {1'b0, divisor_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= ggcs_pkg::DivCntW'(ggcs_pkg::DivNW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q     <= '0;
      quo_q     <= dividend_i;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[ggcs_pkg::DivDW-1:0] : trial[ggcs_pkg::DivDW-1:0];
      quo_q <= {quo_q[ggcs_pkg::DivNW-2:0], fits};
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = quo_q;

endmodule

>>> rtl/geo_grid_cell_store_top.sv
// top level: config registers, item sequencer, cell memory and output register
// reset starts a clearing pass over all 65536 cells, reset-value empty marker to one cell a cycle, input stalled
// a hit runs the column and row divisions as two passes of the shared 23-step divider, after
// up to 3 longitude wrap steps; after a box or spacing change the first hit also recomputes
// width and height; a miss is found at the box check, or at the cell range or index check
// one item at a time; the next word is taken while the result waits in the output
module geo_grid_cell_store_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [ggcs_pkg::CmdW-1:0]        command_i,
  input  logic signed [ggcs_pkg::CoordW-1:0] lat_i,
  input  logic signed [ggcs_pkg::CoordW-1:0] lon_i,
  input  logic signed [ggcs_pkg::ValueW-1:0] sample_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [ggcs_pkg::ValueW-1:0] cell_value_o,
  output logic                             in_grid_o,
  output logic [ggcs_pkg::IndexW-1:0]      cell_index_o,
  input  logic                             cfg_we_i,
  input  logic [ggcs_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [ggcs_pkg::CfgDataW-1:0]    cfg_data_i
);

  localparam int unsigned LonW  = ggcs_pkg::LonW;
  localparam int unsigned QuoW  = ggcs_pkg::QuoW;
  localparam int unsigned CW    = ggcs_pkg::CoordW;
  localparam int unsigned SW    = ggcs_pkg::SpacingW;
  localparam int unsigned VW    = ggcs_pkg::ValueW;
  localparam int unsigned AW    = ggcs_pkg::GridAw;
  localparam int unsigned PW    = ggcs_pkg::ProdW;

  typedef enum logic [1:0] {
    CmdRead    = 2'd0,
    CmdWrite   = 2'd1,
    CmdAverage = 2'd2,
    CmdSpare   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    CfgLatLowest  = 3'd0,
    CfgLatHighest = 3'd1,
    CfgLonLowest  = 3'd2,
    CfgLonHighest = 3'd3,
    CfgLatSpacing = 3'd4,
    CfgLonSpacing = 3'd5,
    CfgEmpty      = 3'd6,
    CfgNone       = 3'd7
  } cfg_e;

  typedef enum logic [1:0] {
    DivW   = 2'd0,
    DivH   = 2'd1,
    DivCol = 2'd2,
    DivRow = 2'd3
  } div_sel_e;

  typedef enum logic [3:0] {
    SClear,
    SIdle,
    SWrap,
    SCheck,
    SDivGo,
    SDivWait,
    SMul,
    SIdx,
    SRead,
    SModify,
    SOut
  } state_e;

  // config registers
  logic signed [CW-1:0] lat_lo_q, lat_hi_q, lon_lo_q, lon_hi_q;
  logic [SW-1:0]        lat_sp_q, lon_sp_q;
  logic [VW-1:0]        empty_q;

  cfg_e cfg_sel;
  assign cfg_sel = cfg_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_lo_q <= CW'(-90000);
      lat_hi_q <= CW'(90000);
      lon_lo_q <= CW'(-180000);
      lon_hi_q <= CW'(180000);
      lat_sp_q <= SW'(1000);
      lon_sp_q <= SW'(1000);
      empty_q  <= ggcs_pkg::EmptyReset;
    end else if (cfg_we_i) begin
      unique case (cfg_sel)
        CfgLatLowest:  lat_lo_q <= cfg_data_i[CW-1:0];
        CfgLatHighest: lat_hi_q <= cfg_data_i[CW-1:0];
        CfgLonLowest:  lon_lo_q <= cfg_data_i[CW-1:0];
        CfgLonHighest: lon_hi_q <= cfg_data_i[CW-1:0];
        CfgLatSpacing: lat_sp_q <= cfg_data_i[SW-1:0];
        CfgLonSpacing: lon_sp_q <= cfg_data_i[SW-1:0];
        CfgEmpty:      empty_q  <= cfg_data_i[VW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer registers
  state_e               state_q;
  div_sel_e             div_sel_q;
  logic [AW-1:0]        clr_cnt_q;
  logic                 dims_valid_q;
  cmd_e                 cmd_q;
  logic signed [LonW-1:0] lon_q;
  logic signed [CW-1:0] lat_q;
  logic [VW-1:0]        sample_q;
  logic                 wrap_pos_q, wrap_neg_q;
  logic [CW-1:0]        lon_off_q, lat_off_q;
  logic [QuoW-1:0]      w_q, h_q, col_q, row_q;
  logic [PW-1:0]        prod_q;
  logic [AW-1:0]        idx_q;
  logic                 hit_q;
  logic [VW-1:0]        value_q;
  logic                 out_valid_q;
  logic [VW-1:0]        out_value_q;
  logic                 out_hit_q;
  logic [ggcs_pkg::IndexW-1:0] out_index_q;

  // datapath
  logic signed [LonW-1:0] lat_ext, lat_lo_ext, lat_hi_ext, lon_lo_ext, lon_hi_ext;
  logic signed [LonW-1:0] lon_span, lat_span, lon_off, lat_off;
  logic                   box_miss;
  logic [PW-1:0]          idx_full;
  logic [ggcs_pkg::DivNW-1:0] div_dividend;
  logic [ggcs_pkg::DivDW-1:0] div_divisor;
  logic [ggcs_pkg::DivNW-1:0] div_quo;
  ggcs_pkg::div_status_t      div_status;
  logic                   div_start;
  logic [VW:0]            avg_sum;
  logic [VW-1:0]          new_value;
  logic [VW-1:0]          ram_rdata;
  logic [VW-1:0]          ram_wdata;
  logic [AW-1:0]          ram_addr;
  logic                   ram_en, ram_we;
  logic                   is_store;
  logic                   out_free;
  logic                   accept;

  assign lat_ext    = LonW'(lat_q);
  assign lat_lo_ext = LonW'(lat_lo_q);
  assign lat_hi_ext = LonW'(lat_hi_q);
  assign lon_lo_ext = LonW'(lon_lo_q);
  assign lon_hi_ext = LonW'(lon_hi_q);
  assign lon_span   = lon_hi_ext - lon_lo_ext;
  assign lat_span   = lat_hi_ext - lat_lo_ext;
  assign lon_off    = lon_q - lon_lo_ext;
  assign lat_off    = lat_ext - lat_lo_ext;

  assign box_miss = (lat_sp_q == '0) || (lon_sp_q == '0)
                 || (lon_q < lon_lo_ext) || (lon_q > lon_hi_ext)
                 || (lat_ext < lat_lo_ext) || (lat_ext > lat_hi_ext);

  assign idx_full = prod_q + PW'(col_q);

  always_comb begin
    unique case (div_sel_q)
      DivW: begin
        div_dividend = ggcs_pkg::DivNW'(lon_span[CW-1:0]);
        div_divisor  = {1'b0, lon_sp_q};
      end
      DivH: begin
        div_dividend = ggcs_pkg::DivNW'(lat_span[CW-1:0]);
        div_divisor  = {1'b0, lat_sp_q};
      end
      DivCol: begin
        div_dividend = {1'b0, lon_off_q, 1'b0} + ggcs_pkg::DivNW'(lon_sp_q);
        div_divisor  = {lon_sp_q, 1'b0};
      end
      DivRow: begin
        div_dividend = {1'b0, lat_off_q, 1'b0} + ggcs_pkg::DivNW'(lat_sp_q);
        div_divisor  = {lat_sp_q, 1'b0};
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
      end
    endcase
  end

  assign div_start = (state_q == SDivGo);

  ggcs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .status_o   (div_status),
    .quotient_o (div_quo)
  );

  assign avg_sum = {ram_rdata[VW-1], ram_rdata} + {sample_q[VW-1], sample_q};

  always_comb begin
    unique case (cmd_q)
      CmdWrite:   new_value = sample_q;
      CmdAverage: new_value = (ram_rdata == empty_q) ? sample_q : avg_sum[VW:1];
      default:    new_value = ram_rdata;
    endcase
  end

  assign is_store  = (cmd_q == CmdWrite) || (cmd_q == CmdAverage);
  assign ram_en    = (state_q == SClear) || (state_q == SRead)
                  || ((state_q == SModify) && is_store);
  assign ram_we    = (state_q == SClear) || ((state_q == SModify) && is_store);
  assign ram_addr  = (state_q == SClear) ? clr_cnt_q : idx_q;
  assign ram_wdata = (state_q == SClear) ? ggcs_pkg::EmptyReset : new_value;

  ggcs_ram #(
    .Width (VW),
    .Depth (ggcs_pkg::GridCells)
  ) u_cells (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o = (state_q != SIdle);
  assign accept     = in_valid_i && (state_q == SIdle);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SClear;
      div_sel_q    <= DivW;
      clr_cnt_q    <= '0;
      dims_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      hit_q        <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != SOut)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        SClear: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == AW'(ggcs_pkg::GridCells - 1)) begin
            state_q <= SIdle;
          end
        end
        SIdle: begin
          if (accept) begin
            cmd_q      <= cmd_e'(command_i);
            lat_q      <= lat_i;
            lon_q      <= LonW'(lon_i);
            sample_q   <= sample_i;
            wrap_pos_q <= LonW'(lon_i) > ggcs_pkg::WrapHalf;
            wrap_neg_q <= LonW'(lon_i) < -ggcs_pkg::WrapHalf;
            state_q    <= SWrap;
          end
        end
        SWrap: begin
          if (wrap_pos_q && (lon_q >= ggcs_pkg::WrapHalf)) begin
            lon_q <= lon_q - ggcs_pkg::WrapFull;
          end else if (wrap_neg_q && (lon_q <= -ggcs_pkg::WrapHalf)) begin
            lon_q <= lon_q + ggcs_pkg::WrapFull;
          end else begin
            state_q <= SCheck;
          end
        end
        SCheck: begin
          lon_off_q <= lon_off[CW-1:0];
          lat_off_q <= lat_off[CW-1:0];
          if (box_miss) begin
            hit_q   <= 1'b0;
            state_q <= SOut;
          end else begin
            div_sel_q <= dims_valid_q ? DivCol : DivW;
            state_q   <= SDivGo;
          end
        end
        SDivGo: begin
          state_q <= SDivWait;
        end
        SDivWait: begin
          if (div_status.done) begin
            unique case (div_sel_q)
              DivW: begin
                w_q       <= div_quo[QuoW-1:0] + 1'b1;
                div_sel_q <= DivH;
                state_q   <= SDivGo;
              end
              DivH: begin
                h_q          <= div_quo[QuoW-1:0] + 1'b1;
                dims_valid_q <= 1'b1;
                div_sel_q    <= DivCol;
                state_q      <= SDivGo;
              end
              DivCol: begin
                col_q     <= div_quo[QuoW-1:0];
                div_sel_q <= DivRow;
                state_q   <= SDivGo;
              end
              DivRow: begin
                row_q   <= div_quo[QuoW-1:0];
                state_q <= SMul;
              end
              default: ;
            endcase
          end
        end
        SMul: begin
          prod_q <= w_q * row_q;
          if ((col_q >= w_q) || (row_q >= h_q)) begin
            hit_q   <= 1'b0;
            state_q <= SOut;
          end else begin
            state_q <= SIdx;
          end
        end
        SIdx: begin
          idx_q <= idx_full[AW-1:0];
          if (idx_full[PW-1:AW] != '0) begin
            hit_q   <= 1'b0;
            state_q <= SOut;
          end else begin
            hit_q   <= 1'b1;
            state_q <= SRead;
          end
        end
        SRead: begin
          state_q <= SModify;
        end
        SModify: begin
          value_q <= new_value;
          state_q <= SOut;
        end
        SOut: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_hit_q   <= hit_q;
            out_value_q <= hit_q ? value_q : empty_q;
            out_index_q <= hit_q ? ggcs_pkg::IndexW'(idx_q) : '0;
            state_q     <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
      if (cfg_we_i && (cfg_index_i <= CfgLonSpacing)) begin
        dims_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign cell_value_o = out_value_q;
  assign in_grid_o    = out_hit_q;
  assign cell_index_o = out_index_q;

endmodule
